FILE: src/adf_pkg.sv
package adf_pkg;

   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth = 48;
   localparam int NameRegBytes = 6;

   localparam logic [CsrIndexWidth-1:0] CSR_TARGET_UUID = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_TARGET_NAME = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_NAME_LENGTH = 2'd2;

   localparam logic [15:0] TARGET_UUID_RESET = 16'h1812;
   localparam logic [47:0] TARGET_NAME_RESET = 48'h6959_6F61_6958;
   localparam logic [2:0] NAME_LENGTH_RESET = 3'd6;

   localparam logic [7:0] AD_UUID16_INCOMPLETE = 8'h02;
   localparam logic [7:0] AD_UUID16_COMPLETE = 8'h03;
   localparam logic [7:0] AD_NAME_SHORT = 8'h08;
   localparam logic [7:0] AD_NAME_COMPLETE = 8'h09;

   typedef enum logic [1:0] {
      PHASE_LEN,
      PHASE_TYPE,
      PHASE_DATA
   } phase_type;

   typedef enum logic [1:0] {
      KIND_OTHER,
      KIND_UUID,
      KIND_NAME
   } kind_type;

   typedef struct packed {
      logic uuid_found;
      logic name_found;
      logic device_match;
   } result_type;

endpackage

FILE: src/adv_data_device_filter.sv
// Advertising data device filter.
// The req_ channel carries one advertising payload byte per item, with
// req_last_byte set on the final byte of a payload. The rsp_ channel gives
// one item per payload: the service UUID match, the name prefix match and
// their AND. Bytes that are not last give no item.
// A byte is taken into the input register and parsed from there.
// If it is last, its item is loaded into the output register when it is
// parsed, and rsp_valid is driven from that register.
// One item is accepted every cycle unless a last byte waits on the output.
// The csr_ port writes the target UUID, the name prefix and the prefix
// length; write it only while no payload is in flight.
// Reset clears the parser, loads the default UUID, prefix and length, and
// empties both registers. When the receiver stalls, the result stays in
// the output register; non-last bytes still go on, and the input stalls
// only when a last byte finds the output register full.
module adv_data_device_filter import adf_pkg::*; #(
   parameter int NAME_BYTES = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_adv_byte,
   input  logic                      req_last_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_uuid_found,
   output logic                      rsp_name_found,
   output logic                      rsp_device_match,
   input  logic                      csr_we,
   input  logic [CsrIndexWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0]   csr_wdata
);

   logic [15:0]  target_uuid_ff;
   logic [47:0]  target_name_ff;
   logic [2:0]   name_length_ff;

   logic         in_valid_ff;
   logic [7:0]   in_byte_ff;
   logic         in_last_ff;

   logic         out_valid_ff;
   result_type   out_result_ff;

   logic         step;
   result_type   result;

   assign step = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_uuid_ff <= TARGET_UUID_RESET;
         target_name_ff <= TARGET_NAME_RESET;
         name_length_ff <= NAME_LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET_UUID: target_uuid_ff <= csr_wdata[15:0];
            CSR_TARGET_NAME: target_name_ff <= csr_wdata[47:0];
            CSR_NAME_LENGTH: name_length_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_adv_byte;
         in_last_ff <= req_last_byte;
      end
   end

   adf_parser #(
      .NAME_BYTES (NAME_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .adv_byte    (in_byte_ff),
      .last_byte   (in_last_ff),
      .target_uuid (target_uuid_ff),
      .target_name (target_name_ff),
      .name_length (name_length_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_last_ff) begin
         out_result_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_uuid_found = out_result_ff.uuid_found;
   assign rsp_name_found = out_result_ff.name_found;
   assign rsp_device_match = out_result_ff.device_match;

endmodule

FILE: src/adf_parser.sv
module adf_parser import adf_pkg::*; #(
   parameter int NAME_BYTES = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        adv_byte,
   input  logic              last_byte,
   input  logic [15:0]       target_uuid,
   input  logic [47:0]       target_name,
   input  logic [2:0]        name_length,
   output result_type        result
);

   localparam int PosWidth = $clog2(NAME_BYTES + 1);
   localparam int LenWidth = (PosWidth > 3) ? PosWidth : 3;
   localparam logic [LenWidth-1:0] NameBytesLen = LenWidth'(NAME_BYTES);
   localparam logic [PosWidth-1:0] PosMax = PosWidth'(NAME_BYTES);

   phase_type            phase_ff, phase_in;
   kind_type             kind_ff, kind_in;
   logic [7:0]           bytes_left_ff, bytes_left_in;
   logic                 odd_ff, odd_in;
   logic [PosWidth-1:0]  pos_ff, pos_in;
   logic [7:0]           uuid_low_ff, uuid_low_in;
   logic                 name_eq_ff, name_eq_in;
   logic                 uuid_seen_ff, uuid_seen_in;
   logic                 name_seen_ff, name_seen_in;

   logic [LenWidth-1:0]  len_ext;
   logic [PosWidth-1:0]  prefix_len;
   logic [7:0]           want;
   logic                 eq_now;
   logic                 uuid_seen_next;
   logic                 name_seen_next;

   always_comb begin
      len_ext = LenWidth'(name_length);
      if (len_ext > NameBytesLen) begin
         prefix_len = PosMax;
      end else begin
         prefix_len = PosWidth'(len_ext);
      end
   end

   // Prefix bytes above the register width compare as zero.
   always_comb begin
      want = '0;
      for (int i = 0; i < NameRegBytes; i++) begin
         if (32'(pos_ff) == i) begin
            want = target_name[8*i +: 8];
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      kind_in = kind_ff;
      bytes_left_in = bytes_left_ff;
      odd_in = odd_ff;
      pos_in = pos_ff;
      uuid_low_in = uuid_low_ff;
      name_eq_in = name_eq_ff;
      uuid_seen_next = uuid_seen_ff;
      name_seen_next = name_seen_ff;
      eq_now = name_eq_ff && (want == adv_byte);

      case (phase_ff)
         PHASE_TYPE: begin
            if (adv_byte == AD_UUID16_INCOMPLETE || adv_byte == AD_UUID16_COMPLETE) begin
               kind_in = KIND_UUID;
            end else if (adv_byte == AD_NAME_SHORT || adv_byte == AD_NAME_COMPLETE) begin
               kind_in = KIND_NAME;
            end else begin
               kind_in = KIND_OTHER;
            end
            odd_in = 1'b0;
            pos_in = '0;
            name_eq_in = 1'b1;
            if (kind_in == KIND_NAME && prefix_len == '0) begin
               name_seen_next = 1'b1;
            end
            bytes_left_in = bytes_left_ff - 8'd1;
            phase_in = (bytes_left_ff == 8'd1) ? PHASE_LEN : PHASE_DATA;
         end
         PHASE_DATA: begin
            if (kind_ff == KIND_UUID) begin
               if (!odd_ff) begin
                  uuid_low_in = adv_byte;
               end else if ({adv_byte, uuid_low_ff} == target_uuid) begin
                  uuid_seen_next = 1'b1;
               end
            end else if (kind_ff == KIND_NAME) begin
               if (pos_ff < prefix_len) begin
                  name_eq_in = eq_now;
                  if (eq_now && (pos_ff + PosWidth'(1)) == prefix_len) begin
                     name_seen_next = 1'b1;
                  end
               end
            end
            odd_in = !odd_ff;
            if (pos_ff != PosMax) begin
               pos_in = pos_ff + PosWidth'(1);
            end
            bytes_left_in = bytes_left_ff - 8'd1;
            if (bytes_left_ff == 8'd1) begin
               phase_in = PHASE_LEN;
            end
         end
         default: begin
            if (adv_byte != 8'd0) begin
               bytes_left_in = adv_byte;
               phase_in = PHASE_TYPE;
            end else begin
               phase_in = PHASE_LEN;
            end
         end
      endcase

      uuid_seen_in = uuid_seen_next;
      name_seen_in = name_seen_next;

      // The last byte closes the payload and restarts the parser.
      if (last_byte) begin
         phase_in = PHASE_LEN;
         kind_in = KIND_OTHER;
         bytes_left_in = '0;
         odd_in = 1'b0;
         pos_in = '0;
         uuid_low_in = '0;
         name_eq_in = 1'b1;
         uuid_seen_in = 1'b0;
         name_seen_in = 1'b0;
      end

      result.uuid_found = uuid_seen_next;
      result.name_found = name_seen_next;
      result.device_match = uuid_seen_next && name_seen_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_LEN;
         kind_ff <= KIND_OTHER;
         bytes_left_ff <= '0;
         odd_ff <= 1'b0;
         pos_ff <= '0;
         uuid_low_ff <= '0;
         name_eq_ff <= 1'b1;
         uuid_seen_ff <= 1'b0;
         name_seen_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         kind_ff <= kind_in;
         bytes_left_ff <= bytes_left_in;
         odd_ff <= odd_in;
         pos_ff <= pos_in;
         uuid_low_ff <= uuid_low_in;
         name_eq_ff <= name_eq_in;
         uuid_seen_ff <= uuid_seen_in;
         name_seen_ff <= name_seen_in;
      end
   end

endmodule

FILE: tb/tb_top.sv
module tb_top;
   import adf_pkg::*;

   localparam int PhaseBytes = 172;
   localparam int DrainCycles = 4;
   localparam int IdleLimit = 5000;
   localparam int MaxPrinted = 40;

   typedef enum {READY_ALWAYS, READY_RANDOM, READY_SPARSE, READY_PERIODIC} ready_mode_type;

   class filter_scoreboard;
      logic [15:0] target_uuid;
      logic [47:0] target_name;
      logic [2:0] name_length;
      phase_type phase;
      kind_type kind;
      logic [7:0] bytes_left;
      logic [7:0] data_pos;
      logic [7:0] uuid_low;
      logic name_equal;
      logic uuid_seen;
      logic name_seen;
      result_type expected_q[$];
      int fails;
      int checked;

      function new();
         target_uuid = TARGET_UUID_RESET;
         target_name = TARGET_NAME_RESET;
         name_length = NAME_LENGTH_RESET;
         fails = 0;
         checked = 0;
         clear();
      endfunction

      function void clear();
         phase = PHASE_LEN;
         kind = KIND_OTHER;
         bytes_left = 8'd0;
         data_pos = 8'd0;
         uuid_low = 8'd0;
         name_equal = 1'b1;
         uuid_seen = 1'b0;
         name_seen = 1'b0;
      endfunction

      function int prefix_bytes();
         return (name_length > NameRegBytes) ? NameRegBytes : int'(name_length);
      endfunction

      function void write_reg(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
         case (idx)
            CSR_TARGET_UUID: target_uuid = data[15:0];
            CSR_TARGET_NAME: target_name = data[47:0];
            CSR_NAME_LENGTH: name_length = data[2:0];
            default: ;
         endcase
      endfunction

      function void take_type(logic [7:0] b);
         if (b == AD_UUID16_INCOMPLETE || b == AD_UUID16_COMPLETE) begin
            kind = KIND_UUID;
         end else if (b == AD_NAME_SHORT || b == AD_NAME_COMPLETE) begin
            kind = KIND_NAME;
         end else begin
            kind = KIND_OTHER;
         end
         data_pos = 8'd0;
         name_equal = 1'b1;
         if (kind == KIND_NAME && prefix_bytes() == 0) name_seen = 1'b1;
      endfunction

      function void take_data(logic [7:0] b);
         int n;
         int p;
         logic eq;
         n = prefix_bytes();
         p = data_pos;
         if (kind == KIND_UUID) begin
            if (p % 2 == 0) begin
               uuid_low = b;
            end else if ({b, uuid_low} == target_uuid) begin
               uuid_seen = 1'b1;
            end
         end else if (kind == KIND_NAME && p < n) begin
            eq = name_equal && (target_name[8*p +: 8] == b);
            name_equal = eq;
            if (eq && p + 1 == n) name_seen = 1'b1;
         end
         if (data_pos != 8'hFF) data_pos++;
      endfunction

      // Advances the parser by one accepted byte; a last byte yields one expected item.
      function void note_byte(logic [7:0] b, logic last);
         result_type r;
         case (phase)
            PHASE_TYPE: begin
               take_type(b);
               bytes_left--;
               phase = (bytes_left == 0) ? PHASE_LEN : PHASE_DATA;
            end
            PHASE_DATA: begin
               take_data(b);
               bytes_left--;
               if (bytes_left == 0) phase = PHASE_LEN;
            end
            default: begin
               if (b != 8'd0) begin
                  bytes_left = b;
                  phase = PHASE_TYPE;
               end
            end
         endcase
         if (last) begin
            r.uuid_found = uuid_seen;
            r.name_found = name_seen;
            r.device_match = uuid_seen && name_seen;
            expected_q.push_back(r);
            clear();
         end
      endfunction

      task report(string what);
         fails++;
         if (fails <= MaxPrinted) $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_result(logic u, logic n, logic d);
         result_type want;
         if (expected_q.size() == 0) begin
            report("result item arrived with none expected");
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (u !== want.uuid_found)
            report($sformatf("uuid_found %b, expected %b", u, want.uuid_found));
         if (n !== want.name_found)
            report($sformatf("name_found %b, expected %b", n, want.name_found));
         if (d !== want.device_match)
            report($sformatf("device_match %b, expected %b", d, want.device_match));
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [7:0] req_adv_byte;
   logic req_last_byte;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_uuid_found;
   logic rsp_name_found;
   logic rsp_device_match;
   logic csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0] csr_wdata;

   filter_scoreboard sb = new();
   logic [7:0] payload[$];
   int burst_left = 0;
   int bytes_sent = 0;
   int settings_used = 1;
   int idle_cycles = 0;

   adv_data_device_filter dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_adv_byte(req_adv_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_uuid_found(rsp_uuid_found),
      .rsp_name_found(rsp_name_found),
      .rsp_device_match(rsp_device_match),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      ready_mode_type mode;
      int left;
      rsp_ready = 1'b0;
      mode = READY_ALWAYS;
      left = 0;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            mode = ready_mode_type'($urandom_range(0, 3));
            left = $urandom_range(20, 120);
         end
         left--;
         case (mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (left % 5 != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_ready)
            sb.check_result(rsp_uuid_found, rsp_name_found, rsp_device_match);
         if (req_valid && req_ready === 1'b1) sb.note_byte(req_adv_byte, req_last_byte);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
         $display("[%0t] no handshake for %0d cycles", $time, IdleLimit);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      req_valid <= 1'b1;
      req_adv_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      bytes_sent++;
   endtask

   // Bursts of back-to-back items, separated by short idle gaps.
   task automatic pace();
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 20);
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_payload();
      for (int i = 0; i < payload.size(); i++) begin
         send_byte(payload[i], i == payload.size() - 1);
         pace();
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] uuid, input logic [47:0] name,
                            input logic [2:0] len);
      logic [47:0] junk;
      junk = {$urandom, 16'($urandom)};
      csr_we <= 1'b1;
      csr_index <= CSR_TARGET_UUID;
      csr_wdata <= {junk[47:16], uuid};
      @(posedge clock);
      sb.write_reg(CSR_TARGET_UUID, {junk[47:16], uuid});
      csr_index <= CSR_TARGET_NAME;
      csr_wdata <= name;
      @(posedge clock);
      sb.write_reg(CSR_TARGET_NAME, name);
      csr_index <= CSR_NAME_LENGTH;
      csr_wdata <= {junk[47:3], len};
      @(posedge clock);
      sb.write_reg(CSR_NAME_LENGTH, {junk[47:3], len});
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Mostly well-formed payloads built around the current targets, some raw noise,
   // and now and then a payload cut short at a random byte.
   function automatic void build_payload();
      int fields;
      int pairs;
      int dl;
      int n;
      logic odd;
      logic [15:0] u;
      logic [7:0] b;
      payload.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 24)) payload.push_back(8'($urandom));
         return;
      end
      fields = $urandom_range(1, 4);
      repeat (fields) begin
         case ($urandom_range(0, 4))
            0: repeat ($urandom_range(1, 2)) payload.push_back(8'd0);
            1: begin
               pairs = $urandom_range(0, 4);
               odd = ($urandom_range(0, 3) == 0);
               payload.push_back(8'(1 + 2 * pairs + odd));
               payload.push_back($urandom_range(0, 1) ? AD_UUID16_COMPLETE
                                                      : AD_UUID16_INCOMPLETE);
               repeat (pairs) begin
                  u = ($urandom_range(0, 2) == 0) ? sb.target_uuid : 16'($urandom);
                  payload.push_back(u[7:0]);
                  payload.push_back(u[15:8]);
               end
               if (odd) begin
                  payload.push_back($urandom_range(0, 1) ? sb.target_uuid[7:0]
                                                         : 8'($urandom));
               end
            end
            2, 3: begin
               n = sb.prefix_bytes();
               dl = $urandom_range(0, n + 4);
               payload.push_back(8'(dl + 1));
               payload.push_back($urandom_range(0, 1) ? AD_NAME_COMPLETE : AD_NAME_SHORT);
               for (int i = 0; i < dl; i++) begin
                  b = (i < NameRegBytes) ? sb.target_name[8*i +: 8] : 8'($urandom);
                  if ($urandom_range(0, 11) == 0) b = 8'($urandom);
                  payload.push_back(b);
               end
            end
            default: begin
               dl = $urandom_range(0, 6);
               payload.push_back(8'(dl + 1));
               repeat (dl + 1) payload.push_back(8'($urandom));
            end
         endcase
      end
      if (payload.size() > 1 && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, payload.size() - 1);
         while (payload.size() > n) void'(payload.pop_back());
      end
   endfunction

   initial begin
      int phase_bytes;
      reset = 1'b1;
      req_valid = 1'b0;
      req_adv_byte = 8'd0;
      req_last_byte = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_TARGET_UUID;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Full match on the default targets: complete UUID list, then complete name.
      payload = '{8'h03, 8'h03, 8'h12, 8'h18,
                  8'h07, 8'h09, 8'h58, 8'h69, 8'h61, 8'h6F, 8'h59, 8'h69};
      send_payload();
      // A payload that is a single padding byte.
      payload = '{8'h00};
      send_payload();
      // Odd incomplete UUID list, an unknown field, and a field cut at its length.
      payload = '{8'h04, 8'h02, 8'hFF, 8'hFF, 8'h12, 8'h02, 8'hFF, 8'h00, 8'h03};
      send_payload();
      // Short name field that ends before the whole prefix.
      payload = '{8'h06, 8'h08, 8'h58, 8'h69, 8'h61, 8'h6F, 8'h59};
      send_payload();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: ;
            1: configure(16'h0000, 48'h0, 3'd1);
            2: configure(16'hFFFF, {48{1'b1}}, 3'd7);
            3: configure(16'($urandom), {$urandom, 16'($urandom)}, 3'd0);
            4: configure(16'($urandom), {$urandom, 16'h0000}, 3'd4);
            5: configure(TARGET_UUID_RESET, TARGET_NAME_RESET, NAME_LENGTH_RESET);
            default: configure(16'($urandom), {$urandom, 16'($urandom)},
                               3'($urandom_range(0, 7)));
         endcase
         phase_bytes = 0;
         while (phase_bytes < PhaseBytes) begin
            build_payload();
            phase_bytes += payload.size();
            send_payload();
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (sb.expected_q.size() != 0)
         sb.report($sformatf("%0d expected items never arrived", sb.expected_q.size()));
      $display("Sent %0d payload bytes under %0d register settings.", bytes_sent, settings_used);
      $display("Compared %0d result items, %0d mismatches.", sb.checked, sb.fails);
      if (sb.fails == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
